// ----- hw/rtl/lspe_pkg.sv -----
package lspe_pkg;

  localparam int SampleBits = 12;
  localparam int NormFracBits = 12;
  localparam int NumCh = 4;
  localparam int NormBits = NormFracBits + 1;
  localparam int DivBits = SampleBits + NormFracBits;
  localparam int SumBits = NormBits + 2;
  localparam int NumBits = NormBits + 3;
  localparam int PosBits = 16;
  localparam int PosShift = 13;
  localparam int QuoBits = NumBits + PosShift;
  localparam int SumFloor = ((1 << NormFracBits) + 99) / 100;

  typedef logic [1:0] op_t;
  localparam op_t OpRestart = 2'd0;
  localparam op_t OpCal = 2'd1;
  localparam op_t OpRun = 2'd2;

  typedef struct packed {
    op_t op;
    logic [SampleBits-1:0] sample_a;
    logic [SampleBits-1:0] sample_b;
    logic [SampleBits-1:0] sample_c;
    logic [SampleBits-1:0] sample_d;
  } in_item_t;

  typedef struct packed {
    logic line_lost;
    logic signed [PosBits-1:0] position;
    logic range_zero;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StNorm, StCent, StDiv, StWait, StOut
  } state_t;

endpackage

// ----- hw/rtl/line_sensor_position_estimator_core.sv -----
// One item is taken at a time. Restart, calibration and unused operations give their result the
// cycle after the input transfer, as does a run item that finds the line lost. Any other run
// item starts four channel lanes side by side, each a 24-step restoring divider; the StCent state
// then combines the lanes, StDiv checks the weak-signal floor and a single 29-step divider forms
// the centroid, a step that is skipped when the signal is too weak to divide. Results sit in an
// output register until transferred, and the next item is accepted the cycle after that.
module line_sensor_position_estimator_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  lspe_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output lspe_pkg::out_item_t out_data
);

  localparam int SB = lspe_pkg::SampleBits;

  lspe_pkg::state_t state_r, state_nxt;
  logic [SB-1:0] min_r [lspe_pkg::NumCh], max_r [lspe_pkg::NumCh];
  logic [SB-1:0] min_nxt [lspe_pkg::NumCh], max_nxt [lspe_pkg::NumCh];
  logic [SB-1:0] in_smp [lspe_pkg::NumCh];
  lspe_pkg::out_item_t res_r, res_nxt;
  logic [lspe_pkg::NumCh-1:0] lane_done;
  logic [lspe_pkg::NormBits-1:0] norm [lspe_pkg::NumCh];
  logic lane_start, div_start, div_done;
  logic [lspe_pkg::SumBits-1:0] sum_r, sum_nxt;
  logic signed [lspe_pkg::NumBits-1:0] num_r, num_nxt;
  logic signed [lspe_pkg::PosBits-1:0] div_q;
  logic [SB+2:0] thr4, b4, c4;
  logic acc;

  assign in_smp[0] = in_data.sample_a;
  assign in_smp[1] = in_data.sample_b;
  assign in_smp[2] = in_data.sample_c;
  assign in_smp[3] = in_data.sample_d;
  assign in_ready = (state_r == lspe_pkg::StIdle);
  assign out_valid = (state_r == lspe_pkg::StOut);
  assign out_data = res_r;
  assign acc = in_valid && in_ready;

  for (genvar g = 0; g < lspe_pkg::NumCh; g++) begin : g_lane
    lspe_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(lane_start), .raw(in_smp[g]),
      .lo(min_r[g]), .hi(max_r[g]), .done(lane_done[g]), .norm(norm[g])
    );
  end

  lspe_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r), .den(sum_r),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    sum_nxt = sum_r;
    num_nxt = num_r;
    lane_start = 1'b0;
    div_start = 1'b0;
    for (int i = 0; i < lspe_pkg::NumCh; i++) begin
      min_nxt[i] = min_r[i];
      max_nxt[i] = max_r[i];
    end
    thr4 = (SB+3)'({min_r[1], 2'b00}) + (SB+3)'(max_r[1]) - (SB+3)'(min_r[1]);
    b4 = {1'b0, in_smp[1], 2'b00};
    c4 = {1'b0, in_smp[2], 2'b00};
    case (state_r)
      lspe_pkg::StIdle: begin
        if (acc) begin
          res_nxt = '0;
          if (in_data.op == lspe_pkg::OpRestart || in_data.op == lspe_pkg::OpCal) begin
            for (int i = 0; i < lspe_pkg::NumCh; i++) begin
              if (in_data.op == lspe_pkg::OpRestart) begin
                min_nxt[i] = in_smp[i];
                max_nxt[i] = in_smp[i];
              end else begin
                if (in_smp[i] < min_r[i]) min_nxt[i] = in_smp[i];
                if (in_smp[i] > max_r[i]) max_nxt[i] = in_smp[i];
              end
            end
            state_nxt = lspe_pkg::StOut;
          end else if (in_data.op == lspe_pkg::OpRun) begin
            if (b4 < thr4 && c4 < thr4) begin
              res_nxt.line_lost = 1'b1;
              state_nxt = lspe_pkg::StOut;
            end else begin
              lane_start = 1'b1;
              state_nxt = lspe_pkg::StNorm;
            end
          end else begin
            state_nxt = lspe_pkg::StOut;
          end
          for (int i = 0; i < lspe_pkg::NumCh; i++)
            if (max_nxt[i] <= min_nxt[i]) res_nxt.range_zero = 1'b1;
        end
      end
      lspe_pkg::StNorm: begin
        if (&lane_done) state_nxt = lspe_pkg::StCent;
      end
      lspe_pkg::StCent: begin
        sum_nxt = lspe_pkg::SumBits'(norm[0]) + lspe_pkg::SumBits'(norm[1])
                + lspe_pkg::SumBits'(norm[2]) + lspe_pkg::SumBits'(norm[3]);
        num_nxt = lspe_pkg::NumBits'(2 * (int'(norm[3]) - int'(norm[0]))
                + int'(norm[2]) - int'(norm[1]));
        state_nxt = lspe_pkg::StDiv;
      end
      lspe_pkg::StDiv: begin
        if (sum_r < lspe_pkg::SumBits'(lspe_pkg::SumFloor)) begin
          state_nxt = lspe_pkg::StOut;
        end else begin
          div_start = 1'b1;
          state_nxt = lspe_pkg::StWait;
        end
      end
      lspe_pkg::StWait: begin
        if (div_done) begin
          res_nxt.position = div_q;
          state_nxt = lspe_pkg::StOut;
        end
      end
      lspe_pkg::StOut: begin
        if (out_ready) state_nxt = lspe_pkg::StIdle;
      end
      default: begin
        state_nxt = lspe_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sum_r <= sum_nxt;
    num_r <= num_nxt;
    if (!rst_n) begin
      state_r <= lspe_pkg::StIdle;
      for (int i = 0; i < lspe_pkg::NumCh; i++) begin
        min_r[i] <= '1;
        max_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < lspe_pkg::NumCh; i++) begin
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_lost |-> out_data.position == '0)
    else $error("lost line with nonzero position");

endmodule

// ----- hw/rtl/lspe_lane.sv -----
module lspe_lane (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [lspe_pkg::SampleBits-1:0] raw,
  input  logic [lspe_pkg::SampleBits-1:0] lo,
  input  logic [lspe_pkg::SampleBits-1:0] hi,
  output logic done,
  output logic [lspe_pkg::NormBits-1:0] norm
);

  localparam int W = lspe_pkg::DivBits;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] quo_r, quo_nxt;
  logic [lspe_pkg::SampleBits:0] rem_r, rem_nxt;
  logic [lspe_pkg::SampleBits-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [lspe_pkg::SampleBits-1:0] clamped;
  logic [lspe_pkg::SampleBits:0] trial;

  always_comb begin
    clamped = raw;
    if (clamped < lo) clamped = lo;
    if (clamped > hi) clamped = hi;
    trial = {rem_r[lspe_pkg::SampleBits-1:0], quo_r[W-1]};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = (hi > lo);
      den_nxt = (hi > lo) ? hi - lo : '0;
      quo_nxt = {clamped - lo, {lspe_pkg::NormFracBits{1'b0}}};
      rem_nxt = '0;
      cnt_nxt = CW'(W);
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign done = !busy_r;
  assign norm = (den_r == '0) ? '0 : quo_r[lspe_pkg::NormBits-1:0];

endmodule

// ----- hw/rtl/lspe_divider.sv -----
module lspe_divider (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [lspe_pkg::NumBits-1:0] num,
  input  logic [lspe_pkg::SumBits-1:0] den,
  output logic done,
  output logic signed [lspe_pkg::PosBits-1:0] quo
);

  localparam int W = lspe_pkg::QuoBits;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] q_r, q_nxt;
  logic [lspe_pkg::SumBits:0] rem_r, rem_nxt;
  logic [lspe_pkg::SumBits-1:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [lspe_pkg::NumBits-1:0] mag;
  logic [lspe_pkg::SumBits:0] trial;
  logic [W-1:0] sq;

  always_comb begin
    mag = num[lspe_pkg::NumBits-1] ? lspe_pkg::NumBits'(-num) : num;
    trial = {rem_r[lspe_pkg::SumBits-1:0], q_r[W-1]};
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      den_nxt = den;
      neg_nxt = num[lspe_pkg::NumBits-1];
      q_nxt = {mag, {lspe_pkg::PosShift{1'b0}}};
      rem_nxt = '0;
      cnt_nxt = CW'(W);
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
    sq = neg_r ? -q_r : q_r;
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign done = !busy_r;
  assign quo = sq[lspe_pkg::PosBits-1:0];

endmodule
